// ----- rtl/hdd_pkg.sv -----
// Package with shared constants, register codes and control types of the duplicate detector.
`default_nettype none

package hdd_pkg;

    localparam int unsigned TABLE_BITS_DEF = 16;
    localparam int unsigned MIN_HASH_BITS  = 8;
    localparam int unsigned KEY_W          = 32;
    localparam int unsigned COUNT_W        = 17;
    localparam int unsigned EPOCH_BITS     = 8;
    localparam int unsigned HBITS_W        = 5;
    localparam int unsigned ADDR_W         = 3;
    localparam int unsigned DATA_W         = 32;

    localparam logic [KEY_W-1:0]   HASH_MULT   = 32'd3141592653;
    localparam logic [KEY_W-1:0]   KEY_MISSING = 32'h8000_0000;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};

    localparam logic [HBITS_W-1:0] HASH_BITS_RST = 5'd16;
    localparam logic               KEEP_RST      = 1'b0;

    // Register index, taken from the word address of the configuration port.
    localparam logic REG_HASH_BITS = 1'b0;
    localparam logic REG_KEEP      = 1'b1;

    typedef struct packed {
        logic accept;
        logic clear_set;
        logic epoch_next;
        logic epoch_restart;
        logic clr_wr;
        logic load_home;
        logic probe_next;
        logic store;
        logic resolve;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic slot_empty;
        logic slot_match;
        logic probe_last;
        logic clr_last;
        logic epoch_last;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

// ----- rtl/hdd_if.sv -----
// Valid/ready channel interfaces for input keys and result beats.
`default_nettype none

interface hdd_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] key;
    logic        first_of_set;

    modport source (output valid, output key, output first_of_set, input ready);
    modport sink   (input valid, input key, input first_of_set, output ready);
endinterface

interface hdd_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] key_out;
    logic        is_duplicate;
    logic [16:0] distinct_count;
    logic        table_full;

    modport source (output valid, output key_out, output is_duplicate,
                    output distinct_count, output table_full, input ready);
    modport sink   (input valid, input key_out, input is_duplicate,
                    input distinct_count, input table_full, output ready);
endinterface

`default_nettype wire

// ----- rtl/hash_duplicate_detector.sv -----
// Top level of the hash-set duplicate detector with its configuration registers.
//
//   Channel   Direction  Contents
//   i_item    in         key, first_of_set
//   o_result  out        key_out, is_duplicate, distinct_count, table_full
//   APB       in/out     hash_bits (0x0), keep_unique_only (0x4)
//
// An item passes through the states HASH, READ, CMP and EMIT from its input beat to its result beat;
// CMP repeats for each slot probed, one slot read of the table RAM per cycle.
// After reset a sweep clears every table slot before the first input beat is taken;
// the same sweep runs again, with the item held, on every 255th set start.
// A result waits in the output register while the next input beat is taken.
`default_nettype none

module hash_duplicate_detector #(
    parameter int unsigned TABLE_BITS = hdd_pkg::TABLE_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    hdd_in_if.sink                            i_item,
    hdd_out_if.source                         o_result,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [hdd_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [hdd_pkg::DATA_W-1:0]   pwdata,
    output logic      [hdd_pkg::DATA_W-1:0]   prdata,
    output logic                              pready
);

    logic [hdd_pkg::HBITS_W-1:0] r_hash_bits;
    logic                        r_keep;
    logic [hdd_pkg::HBITS_W-1:0] w_bits;
    logic                        w_wr;
    logic                        w_in_ready;
    hdd_pkg::t_cmd               w_cmd;
    hdd_pkg::t_stat              w_stat;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash_bits <= hdd_pkg::HASH_BITS_RST;
            r_keep      <= hdd_pkg::KEEP_RST;
        end else if (w_wr) begin
            unique case (paddr[2])
                hdd_pkg::REG_HASH_BITS: r_hash_bits <= pwdata[hdd_pkg::HBITS_W-1:0];
                hdd_pkg::REG_KEEP:      r_keep      <= pwdata[0];
                default:                r_keep      <= r_keep;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            hdd_pkg::REG_HASH_BITS:
                prdata = {{(hdd_pkg::DATA_W-hdd_pkg::HBITS_W){1'b0}}, r_hash_bits};
            hdd_pkg::REG_KEEP:
                prdata = {{(hdd_pkg::DATA_W-1){1'b0}}, r_keep};
            default:
                prdata = '0;
        endcase
    end

    always_comb begin
        if (r_hash_bits < hdd_pkg::HBITS_W'(hdd_pkg::MIN_HASH_BITS)) begin
            w_bits = hdd_pkg::HBITS_W'(hdd_pkg::MIN_HASH_BITS);
        end else if (r_hash_bits > hdd_pkg::HBITS_W'(TABLE_BITS)) begin
            w_bits = hdd_pkg::HBITS_W'(TABLE_BITS);
        end else begin
            w_bits = r_hash_bits;
        end
    end

    hdd_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_item.valid),
        .i_first       (i_item.first_of_set),
        .i_keep_unique (r_keep),
        .o_in_ready    (w_in_ready),
        .o_cmd         (w_cmd),
        .i_stat        (w_stat)
    );

    assign i_item.ready = w_in_ready;

    hdd_dp #(
        .TABLE_BITS (TABLE_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_key            (i_item.key),
        .i_bits           (w_bits),
        .i_out_ready      (o_result.ready),
        .o_out_valid      (o_result.valid),
        .o_key_out        (o_result.key_out),
        .o_is_duplicate   (o_result.is_duplicate),
        .o_distinct_count (o_result.distinct_count),
        .o_table_full     (o_result.table_full)
    );

endmodule

`default_nettype wire

// ----- rtl/hdd_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module hdd_ram #(
    parameter int unsigned WIDTH = 40,
    parameter int unsigned DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// ----- rtl/hdd_ctrl.sv -----
// Controller state machine that sequences clearing, hashing, probing and result beats.
`default_nettype none

module hdd_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_first,
    input  wire logic          i_keep_unique,
    output logic               o_in_ready,
    output hdd_pkg::t_cmd      o_cmd,
    input  wire hdd_pkg::t_stat i_stat
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_READ,
        S_CMP,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_hold;
    logic   n_hold;
    logic   w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_hold  = r_hold;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    o_cmd.epoch_restart = 1'b1;
                    n_hold  = 1'b0;
                    n_state = r_hold ? S_HASH : S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.accept    = 1'b1;
                    o_cmd.clear_set = i_first;
                    if (i_first && i_stat.epoch_last) begin
                        n_hold  = 1'b1;
                        n_state = S_CLEAR;
                    end else begin
                        o_cmd.epoch_next = i_first;
                        n_state = S_HASH;
                    end
                end
            end
            S_HASH: begin
                n_state = S_READ;
            end
            S_READ: begin
                o_cmd.load_home = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (i_stat.slot_empty) begin
                    o_cmd.store   = 1'b1;
                    o_cmd.resolve = 1'b1;
                    n_state = S_EMIT;
                end else if (i_stat.slot_match) begin
                    o_cmd.resolve = 1'b1;
                    n_state = i_keep_unique ? S_IDLE : S_EMIT;
                end else if (i_stat.probe_last) begin
                    o_cmd.resolve = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    o_cmd.probe_next = 1'b1;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_hold  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_hold  <= n_hold;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/hdd_dp.sv -----
// Datapath with key hashing, probe addressing, the slot table and the result register.
`default_nettype none

module hdd_dp #(
    parameter int unsigned TABLE_BITS = hdd_pkg::TABLE_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire hdd_pkg::t_cmd                   i_cmd,
    output hdd_pkg::t_stat                       o_stat,
    input  wire logic [hdd_pkg::KEY_W-1:0]       i_key,
    input  wire logic [hdd_pkg::HBITS_W-1:0]     i_bits,
    input  wire logic                            i_out_ready,
    output logic                                 o_out_valid,
    output logic      [hdd_pkg::KEY_W-1:0]       o_key_out,
    output logic                                 o_is_duplicate,
    output logic      [hdd_pkg::COUNT_W-1:0]     o_distinct_count,
    output logic                                 o_table_full
);

    localparam int unsigned KW    = hdd_pkg::KEY_W;
    localparam int unsigned EW    = hdd_pkg::EPOCH_BITS;
    localparam int unsigned WORD_W = KW + EW;

    logic [KW-1:0]                r_key;
    logic [KW-1:0]                r_prod;
    logic [TABLE_BITS-1:0]        r_addr;
    logic [TABLE_BITS-1:0]        n_addr;
    logic [TABLE_BITS:0]          r_probe;
    logic [TABLE_BITS-1:0]        r_clr;
    logic [EW-1:0]                r_epoch;
    logic [hdd_pkg::COUNT_W-1:0]  r_count;
    logic                         r_dup;
    logic                         r_full;
    logic                         r_out_valid;

    logic [TABLE_BITS-1:0]        w_mask;
    logic [TABLE_BITS:0]          w_size;
    logic [5:0]                   w_shift;
    logic [KW-1:0]                w_hashed;
    logic [TABLE_BITS-1:0]        w_home;
    logic                         w_wr_en;
    logic [TABLE_BITS-1:0]        w_wr_addr;
    logic [WORD_W-1:0]            w_wr_data;
    logic [WORD_W-1:0]            w_rd_data;
    logic                         w_empty;

    assign w_mask   = ~({TABLE_BITS{1'b1}} << i_bits);
    assign w_size   = {1'b0, w_mask} + {{TABLE_BITS{1'b0}}, 1'b1};
    assign w_shift  = 6'd32 - {1'b0, i_bits};
    assign w_hashed = r_prod >> w_shift;
    assign w_home   = (r_key == hdd_pkg::KEY_MISSING) ? '0 : w_hashed[TABLE_BITS-1:0];

    always_comb begin
        if (i_cmd.load_home) begin
            n_addr = w_home;
        end else if (i_cmd.probe_next) begin
            n_addr = (r_addr + {{(TABLE_BITS-1){1'b0}}, 1'b1}) & w_mask;
        end else begin
            n_addr = r_addr;
        end
    end

    assign w_wr_en   = i_cmd.store || i_cmd.clr_wr;
    assign w_wr_addr = i_cmd.clr_wr ? r_clr : r_addr;
    assign w_wr_data = i_cmd.clr_wr ? '0 : {r_epoch, r_key};

    hdd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (2 ** TABLE_BITS)
    ) u_slots (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (n_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_empty = (w_rd_data[WORD_W-1:KW] != r_epoch);

    always_comb begin
        o_stat            = '0;
        o_stat.slot_empty = w_empty;
        o_stat.slot_match = !w_empty && (w_rd_data[KW-1:0] == r_key);
        o_stat.probe_last = (r_probe == w_size);
        o_stat.clr_last   = &r_clr;
        o_stat.epoch_last = &r_epoch;
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        r_prod <= r_key * hdd_pkg::HASH_MULT;
        r_addr <= n_addr;
        if (i_cmd.accept) begin
            r_key <= i_key;
        end
        if (i_cmd.load_home) begin
            r_probe <= {{TABLE_BITS{1'b0}}, 1'b1};
        end else if (i_cmd.probe_next) begin
            r_probe <= r_probe + {{TABLE_BITS{1'b0}}, 1'b1};
        end
        if (i_cmd.resolve) begin
            r_dup  <= !w_empty && (w_rd_data[KW-1:0] == r_key);
            r_full <= !w_empty && (w_rd_data[KW-1:0] != r_key);
        end
        if (i_cmd.load_out) begin
            o_key_out        <= r_key;
            o_is_duplicate   <= r_dup;
            o_distinct_count <= r_count;
            o_table_full     <= r_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_epoch     <= {{(EW-1){1'b0}}, 1'b1};
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr <= r_clr + {{(TABLE_BITS-1){1'b0}}, 1'b1};
            end
            if (i_cmd.epoch_restart) begin
                r_epoch <= {{(EW-1){1'b0}}, 1'b1};
            end else if (i_cmd.epoch_next) begin
                r_epoch <= r_epoch + {{(EW-1){1'b0}}, 1'b1};
            end
            if (i_cmd.clear_set) begin
                r_count <= '0;
            end else if (i_cmd.store && (r_count != hdd_pkg::COUNT_MAX)) begin
                r_count <= r_count + {{(hdd_pkg::COUNT_W-1){1'b0}}, 1'b1};
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ----- tb/hash_duplicate_detector_tb.sv -----
// Testbench for the hash-set duplicate detector: random and directed key streams, self-checked.
`timescale 1ns / 100ps

module hash_duplicate_detector_tb;

    localparam int unsigned SLOTS         = 1 << hdd_pkg::TABLE_BITS_DEF;
    localparam int unsigned SETTLE_CYCLES = 1500;
    localparam int unsigned HOLD_CYCLES   = 200;

    typedef struct {
        logic [hdd_pkg::KEY_W-1:0]   key;
        logic                        dup;
        logic [hdd_pkg::COUNT_W-1:0] count;
        logic                        full;
    } t_dup_result;

    class dup_scoreboard;
        t_dup_result                 pending_results[$];
        int unsigned                 slot_epoch [SLOTS];
        logic [hdd_pkg::KEY_W-1:0]   slot_key [SLOTS];
        int unsigned                 live_epoch  = 1;
        int unsigned                 stored      = 0;
        logic [hdd_pkg::HBITS_W-1:0] hash_bits   = hdd_pkg::HASH_BITS_RST;
        logic                        keep_unique = hdd_pkg::KEEP_RST;
        int unsigned                 errors      = 0;
        int unsigned                 keys_seen   = 0;
        int unsigned                 sets_seen   = 0;
        int unsigned                 beats_seen  = 0;
        int unsigned                 dup_hits    = 0;
        int unsigned                 full_hits   = 0;

        function int unsigned outstanding();
            return pending_results.size();
        endfunction

        function void note_key(logic [hdd_pkg::KEY_W-1:0] key, logic first);
            int unsigned               bits;
            int unsigned               size;
            int unsigned               id;
            int unsigned               n;
            logic [hdd_pkg::KEY_W-1:0] prod;
            logic                      dup;
            logic                      full;
            t_dup_result               r;
            if (first) begin
                live_epoch++;
                stored = 0;
                sets_seen++;
            end
            keys_seen++;
            bits = hash_bits;
            if (bits < hdd_pkg::MIN_HASH_BITS) bits = hdd_pkg::MIN_HASH_BITS;
            if (bits > hdd_pkg::TABLE_BITS_DEF) bits = hdd_pkg::TABLE_BITS_DEF;
            size = 1 << bits;
            prod = hdd_pkg::HASH_MULT * key;
            id = (key == hdd_pkg::KEY_MISSING) ? 0 : (prod >> (32 - bits));
            dup = 1'b0;
            full = 1'b1;
            for (n = 0; n < size; n++) begin
                if (slot_epoch[id] != live_epoch) begin
                    slot_epoch[id] = live_epoch;
                    slot_key[id] = key;
                    if (stored < hdd_pkg::COUNT_MAX) stored++;
                    full = 1'b0;
                    break;
                end
                if (slot_key[id] == key) begin
                    dup = 1'b1;
                    full = 1'b0;
                    break;
                end
                id = (id + 1) & (size - 1);
            end
            if (dup) dup_hits++;
            if (full) full_hits++;
            if (keep_unique && dup) return;
            r.key = key;
            r.dup = dup;
            r.count = stored[hdd_pkg::COUNT_W-1:0];
            r.full = full;
            pending_results.push_back(r);
        endfunction

        function void check_beat(logic [hdd_pkg::KEY_W-1:0] key, logic dup,
                                 logic [hdd_pkg::COUNT_W-1:0] count, logic full);
            t_dup_result r;
            beats_seen++;
            if (pending_results.size() == 0) begin
                $error("unexpected result beat: key_out %h", key);
                errors++;
                return;
            end
            r = pending_results.pop_front();
            if (key !== r.key) begin
                $error("key_out mismatch: expected %h, actual %h", r.key, key);
                errors++;
            end
            if (dup !== r.dup) begin
                $error("is_duplicate mismatch: expected %0d, actual %0d", r.dup, dup);
                errors++;
            end
            if (count !== r.count) begin
                $error("distinct_count mismatch: expected %0d, actual %0d", r.count, count);
                errors++;
            end
            if (full !== r.full) begin
                $error("table_full mismatch: expected %0d, actual %0d", r.full, full);
                errors++;
            end
        endfunction
    endclass

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [hdd_pkg::ADDR_W-1:0] paddr;
    logic [hdd_pkg::DATA_W-1:0] pwdata;
    logic [hdd_pkg::DATA_W-1:0] prdata;
    logic                       pready;

    hdd_in_if  itm ();
    hdd_out_if res ();

    hash_duplicate_detector DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (itm),
        .o_result (res),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    dup_scoreboard sb = new;

    int unsigned tx_max        = 9;
    int unsigned rx_max        = 9;
    int unsigned rx_hold_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #24_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int unsigned wait_n;
        res.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            wait_n = (rx_max != 0) ? $urandom_range(0, rx_max) : 0;
            if (rx_hold_cycles != 0) begin
                wait_n = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (wait_n != 0) begin
                res.ready <= 1'b0;
                repeat (wait_n) @(posedge i_clk);
            end
            res.ready <= 1'b1;
            do @(posedge i_clk); while (res.valid !== 1'b1 || res.ready !== 1'b1);
            sb.check_beat(res.key_out, res.is_duplicate, res.distinct_count, res.table_full);
        end
    end

    task automatic push_key(input logic [hdd_pkg::KEY_W-1:0] key, input logic first);
        int unsigned gap;
        gap = (tx_max != 0) ? $urandom_range(0, tx_max) : 0;
        if (gap != 0) begin
            itm.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        itm.valid <= 1'b1;
        itm.key <= key;
        itm.first_of_set <= first;
        do @(posedge i_clk); while (itm.ready !== 1'b1);
        sb.note_key(key, first);
    endtask

    task automatic pause_until_drained();
        itm.valid <= 1'b0;
        do @(posedge i_clk); while (sb.outstanding() != 0);
    endtask

    task automatic settle();
        pause_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic idx, input logic [hdd_pkg::DATA_W-1:0] value);
        logic [hdd_pkg::ADDR_W-1:0] addr;
        logic [hdd_pkg::DATA_W-1:0] readback;
        addr = {idx, 2'b00};
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        readback = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        if (idx == hdd_pkg::REG_HASH_BITS) begin
            sb.hash_bits = value[hdd_pkg::HBITS_W-1:0];
            if (readback[hdd_pkg::HBITS_W-1:0] !== value[hdd_pkg::HBITS_W-1:0]) begin
                $error("hash_bits readback mismatch: expected %0d, actual %0d",
                       value[hdd_pkg::HBITS_W-1:0], readback[hdd_pkg::HBITS_W-1:0]);
                sb.errors++;
            end
        end else begin
            sb.keep_unique = value[0];
            if (readback[0] !== value[0]) begin
                $error("keep_unique_only readback mismatch: expected %0d, actual %0d",
                       value[0], readback[0]);
                sb.errors++;
            end
        end
    endtask

    task automatic run_sets(input int unsigned n_items, input int unsigned max_set);
        logic [hdd_pkg::KEY_W-1:0] pool [16];
        int unsigned               pool_n;
        int unsigned               left;
        int unsigned               pick;
        int unsigned               i;
        int unsigned               j;
        logic [hdd_pkg::KEY_W-1:0] key;
        logic                      first;
        left = 0;
        pool_n = 1;
        for (i = 0; i < n_items; i++) begin
            first = 1'b0;
            if (left == 0) begin
                left = $urandom_range(1, max_set);
                pool_n = $urandom_range(1, 16);
                for (j = 0; j < pool_n; j++) pool[j] = $urandom;
                first = !(i == 0 && $urandom_range(0, 2) == 0);
            end
            left--;
            pick = $urandom_range(0, 15);
            if (pick < 11) key = pool[$urandom_range(0, pool_n - 1)];
            else if (pick < 13) key = $urandom;
            else if (pick == 13) key = hdd_pkg::KEY_MISSING;
            else begin
                case ($urandom_range(0, 3))
                    0: key = 32'h0000_0000;
                    1: key = 32'h0000_0001;
                    2: key = 32'hFFFF_FFFF;
                    default: key = 32'h7FFF_FFFF;
                endcase
            end
            if ($urandom_range(0, 99) == 0) first = 1'b1;
            if ($urandom_range(0, 39) == 0) pause_until_drained();
            push_key(key, first);
        end
    endtask

    initial begin
        logic [hdd_pkg::KEY_W-1:0] fill_keys[$];
        logic [hdd_pkg::KEY_W-1:0] key;
        logic [4:0]                hb;
        int unsigned               ph;
        int unsigned               i;
        int unsigned               guard;
        t_dup_result               lost;

        i_rst_n <= 1'b0;
        itm.valid <= 1'b0;
        itm.key <= '0;
        itm.first_of_set <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        push_key(32'h0000_0000, 1'b1);
        push_key(hdd_pkg::KEY_MISSING, 1'b0);
        push_key(hdd_pkg::KEY_MISSING, 1'b0);
        push_key(32'h0000_0000, 1'b0);
        push_key(32'h7FFF_FFFF, 1'b0);
        push_key(32'hFFFF_FFFF, 1'b0);
        push_key(32'h0000_0001, 1'b0);
        push_key(32'hFFFF_FFFF, 1'b0);
        push_key(32'h7FFF_FFFF, 1'b0);
        push_key(hdd_pkg::KEY_MISSING, 1'b1);
        push_key(32'h0000_0000, 1'b0);
        push_key(hdd_pkg::KEY_MISSING, 1'b0);
        settle();
        write_register(hdd_pkg::REG_KEEP, 32'hFFFF_FFFF);
        push_key(32'h0000_0000, 1'b0);
        push_key(32'h5555_AAAA, 1'b0);
        push_key(32'h5555_AAAA, 1'b0);
        push_key(hdd_pkg::KEY_MISSING, 1'b1);
        settle();
        write_register(hdd_pkg::REG_HASH_BITS, 32'hFFFF_FFE0);
        write_register(hdd_pkg::REG_KEEP, 32'h0000_0000);
        push_key(32'hAAAA_5555, 1'b0);
        push_key(hdd_pkg::KEY_MISSING, 1'b0);
        push_key(32'h8000_0001, 1'b0);
        settle();
        write_register(hdd_pkg::REG_HASH_BITS, 32'h0000_001F);
        push_key(hdd_pkg::KEY_MISSING, 1'b0);
        push_key(32'h1234_5678, 1'b1);

        // Fill a 256-slot table with 290 keys, some of them repeats, then keep using it under other settings.
        settle();
        write_register(hdd_pkg::REG_HASH_BITS, 32'd8);
        tx_max = 0;
        rx_max = 0;
        for (i = 0; i < 290; i++) begin
            key = ($urandom_range(0, 7) == 0 && fill_keys.size() != 0) ?
                  fill_keys[$urandom_range(0, fill_keys.size() - 1)] : $urandom;
            fill_keys.push_back(key);
            push_key(key, i == 0);
        end
        settle();
        write_register(hdd_pkg::REG_KEEP, 32'd1);
        rx_max = 9;
        for (i = 0; i < 40; i++) begin
            key = $urandom_range(0, 1) ? fill_keys[$urandom_range(0, fill_keys.size() - 1)]
                                       : $urandom;
            push_key(key, 1'b0);
        end
        settle();
        write_register(hdd_pkg::REG_HASH_BITS, 32'd9);
        write_register(hdd_pkg::REG_KEEP, 32'd0);
        tx_max = 9;
        for (i = 0; i < 30; i++) begin
            key = $urandom_range(0, 1) ? fill_keys[$urandom_range(0, fill_keys.size() - 1)]
                                       : $urandom;
            push_key(key, 1'b0);
        end

        for (ph = 0; ph < 8; ph++) begin
            settle();
            case ($urandom_range(0, 9))
                6: hb = 5'd8;
                7: hb = 5'd16;
                8: hb = 5'($urandom_range(0, 7));
                9: hb = 5'($urandom_range(17, 31));
                default: hb = 5'($urandom_range(8, 16));
            endcase
            write_register(hdd_pkg::REG_HASH_BITS, {$urandom} & 32'hFFFF_FFE0 | hb);
            write_register(hdd_pkg::REG_KEEP, $urandom);
            tx_max = $urandom_range(0, 1) ? 9 : 0;
            rx_max = $urandom_range(0, 1) ? 9 : 0;
            if (ph == 2) begin
                tx_max = 0;
                rx_hold_cycles = HOLD_CYCLES;
            end
            run_sets(100, (ph % 2 == 1) ? 2 : 30);
        end

        itm.valid <= 1'b0;
        guard = 0;
        while (sb.outstanding() != 0 && guard < 400_000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (sb.outstanding() != 0) begin
            lost = sb.pending_results.pop_front();
            $error("result for key %h never arrived", lost.key);
            sb.errors++;
        end

        $display("Sent %0d keys in %0d sets and checked %0d result beats.",
                 sb.keys_seen, sb.sets_seen, sb.beats_seen);
        $display("Predicted %0d duplicates and %0d keys rejected by a full table.",
                 sb.dup_hits, sb.full_hits);
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/hdd_pkg.sv
rtl/hdd_if.sv
rtl/hdd_ram.sv
rtl/hdd_ctrl.sv
rtl/hdd_dp.sv
rtl/hash_duplicate_detector.sv
tb/hash_duplicate_detector_tb.sv
